// ===== sv/lcmfn_pkg.sv =====
// ----------------------------------------------------------------------------
// lcmfn_pkg
// Shared types and constants for the lcm-of-1..n modulo prime unit.
// ----------------------------------------------------------------------------
package lcmfn_pkg;

    localparam int unsigned PROD_W = 30;

    localparam logic [PROD_W-1:0] LCM_MOD     = 30'd1000000007;
    localparam logic [31:0]       LCM_MOD_X1  = 32'd1000000007;
    localparam logic [31:0]       LCM_MOD_X2  = 32'd2000000014;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_OUTER,
        ST_TEST,
        ST_MARK,
        ST_SCAN,
        ST_SCAN_TEST,
        ST_POW,
        ST_MUL,
        ST_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;        // latch n, reset counters and product
        logic clr_adv;     // write 0 at clear index, step it
        logic sv_rd;       // read map at sieve index i
        logic sv_next_i;   // i <= i + 1
        logic mark_start;  // j <= i * i
        logic mark_adv;    // write 1 at j, j <= j + i
        logic scan_rd;     // read map at p
        logic scan_next;   // p <= p + 1
        logic pow_start;   // pw <= p
        logic pow_adv;     // pw <= pw * p
        logic mul_start;   // start bit-serial modular multiply
        logic mul_adv;     // one multiply bit
        logic out_load;    // move product into output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic sv_done;
        logic rd_comp;
        logic mark_last;
        logic scan_done;
        logic pow_done;
        logic mul_last;
        logic out_busy;
    } status_t;

endpackage

// ===== sv/lcmfn_ctrl.sv =====
// ----------------------------------------------------------------------------
// lcmfn_ctrl
// Sequencer: clear pass, sieve, prime scan, prime-power build, multiply.
// ----------------------------------------------------------------------------
module lcmfn_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  lcmfn_pkg::status_t sts,
    output lcmfn_pkg::cmd_t    cmd
);
    import lcmfn_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CLEAR;
                end
            end
            ST_CLEAR: begin
                cmd.clr_adv = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_OUTER;
                end
            end
            ST_OUTER: begin
                if (sts.sv_done) begin
                    state_next = ST_SCAN;
                end else begin
                    cmd.sv_rd  = 1'b1;
                    state_next = ST_TEST;
                end
            end
            ST_TEST: begin
                if (sts.rd_comp) begin
                    cmd.sv_next_i = 1'b1;
                    state_next    = ST_OUTER;
                end else begin
                    cmd.mark_start = 1'b1;
                    state_next     = ST_MARK;
                end
            end
            ST_MARK: begin
                cmd.mark_adv = 1'b1;
                if (sts.mark_last) begin
                    cmd.sv_next_i = 1'b1;
                    state_next    = ST_OUTER;
                end
            end
            ST_SCAN: begin
                if (sts.scan_done) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.scan_rd = 1'b1;
                    state_next  = ST_SCAN_TEST;
                end
            end
            ST_SCAN_TEST: begin
                if (sts.rd_comp) begin
                    cmd.scan_next = 1'b1;
                    state_next    = ST_SCAN;
                end else begin
                    cmd.pow_start = 1'b1;
                    state_next    = ST_POW;
                end
            end
            ST_POW: begin
                if (sts.pow_done) begin
                    cmd.mul_start = 1'b1;
                    state_next    = ST_MUL;
                end else begin
                    cmd.pow_adv = 1'b1;
                end
            end
            ST_MUL: begin
                cmd.mul_adv = 1'b1;
                if (sts.mul_last) begin
                    cmd.scan_next = 1'b1;
                    state_next    = ST_SCAN;
                end
            end
            ST_DONE: begin
                if (!sts.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/lcmfn_dp.sv =====
// ----------------------------------------------------------------------------
// lcmfn_dp
// Datapath: composite bitmap memory, sieve/scan counters, prime-power
// multiplier and a bit-serial multiply modulo 1000000007.
// ----------------------------------------------------------------------------
module lcmfn_dp #(
    parameter int unsigned MAX_N = 16384
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  lcmfn_pkg::cmd_t                     cmd,
    output lcmfn_pkg::status_t                  sts,
    input  logic [14:0]                         limit_in,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [lcmfn_pkg::PROD_W-1:0]        out_data
);
    import lcmfn_pkg::*;

    localparam int unsigned NW  = $clog2(MAX_N + 1);  // holds 0..MAX_N
    localparam int unsigned CW  = NW + 1;             // counters that pass n
    localparam int unsigned BCW = $clog2(NW + 1);

    localparam logic [NW-1:0]  N_MAX  = NW'(MAX_N);
    localparam logic [BCW-1:0] BC_END = BCW'(NW - 1);

    // bitmap: 1 = composite
    logic map_mem [0:MAX_N];
    logic rdata_reg;

    logic [NW-1:0]     n_reg;
    logic [NW-1:0]     k_reg;
    logic [CW-1:0]     i_reg;
    logic [CW-1:0]     j_reg;
    logic [CW-1:0]     p_reg;
    logic [NW-1:0]     pw_reg;
    logic [NW-1:0]     sh_reg;
    logic [BCW-1:0]    bc_reg;
    logic [PROD_W-1:0] acc_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] out_data_reg;
    logic              out_valid_reg;

    logic [NW-1:0]     n_sat;
    logic [2*CW-1:0]   i_sq;
    logic [2*CW-1:0]   pw_mul;
    logic [CW:0]       j_step;
    logic [31:0]       mac;
    logic [PROD_W-1:0] mac_red;

    logic              mem_we;
    logic              mem_wd;
    logic              mem_re;
    logic [NW-1:0]     mem_addr;

    assign n_sat = ({17'd0, limit_in} > 32'(MAX_N)) ? N_MAX : NW'(limit_in);

    assign i_sq   = (2*CW)'(i_reg) * (2*CW)'(i_reg);
    assign pw_mul = (2*CW)'(pw_reg) * (2*CW)'(p_reg);
    assign j_step = {1'b0, j_reg} + {1'b0, i_reg};

    // acc*2 + bit*prod < 3*M, fold back with at most one of two subtracts
    assign mac = {1'b0, acc_reg, 1'b0} + (sh_reg[NW-1] ? {2'b00, prod_reg} : 32'd0);
    always_comb begin
        if (mac >= LCM_MOD_X2) begin
            mac_red = PROD_W'(mac - LCM_MOD_X2);
        end else if (mac >= LCM_MOD_X1) begin
            mac_red = PROD_W'(mac - LCM_MOD_X1);
        end else begin
            mac_red = PROD_W'(mac);
        end
    end

    always_comb begin
        mem_we   = cmd.clr_adv | cmd.mark_adv;
        mem_wd   = cmd.mark_adv;
        mem_re   = cmd.sv_rd | cmd.scan_rd;
        mem_addr = k_reg;
        if (cmd.mark_adv) begin
            mem_addr = j_reg[NW-1:0];
        end else if (cmd.sv_rd) begin
            mem_addr = i_reg[NW-1:0];
        end else if (cmd.scan_rd) begin
            mem_addr = p_reg[NW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            map_mem[mem_addr] <= mem_wd;
        end
        if (mem_re) begin
            rdata_reg <= map_mem[mem_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            n_reg    <= n_sat;
            k_reg    <= '0;
            i_reg    <= CW'(2);
            p_reg    <= CW'(2);
            prod_reg <= PROD_W'(1);
        end
        if (cmd.clr_adv) begin
            k_reg <= k_reg + NW'(1);
        end
        if (cmd.sv_next_i) begin
            i_reg <= i_reg + CW'(1);
        end
        if (cmd.mark_start) begin
            j_reg <= i_sq[CW-1:0];
        end
        if (cmd.mark_adv) begin
            j_reg <= j_step[CW-1:0];
        end
        if (cmd.scan_next) begin
            p_reg <= p_reg + CW'(1);
        end
        if (cmd.pow_start) begin
            pw_reg <= p_reg[NW-1:0];
        end
        if (cmd.pow_adv) begin
            pw_reg <= pw_mul[NW-1:0];
        end
        if (cmd.mul_start) begin
            acc_reg <= '0;
            sh_reg  <= pw_reg;
            bc_reg  <= '0;
        end
        if (cmd.mul_adv) begin
            acc_reg <= mac_red;
            sh_reg  <= sh_reg << 1;
            bc_reg  <= bc_reg + BCW'(1);
            if (bc_reg == BC_END) begin
                prod_reg <= mac_red;
            end
        end
        if (cmd.out_load) begin
            out_data_reg <= prod_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign sts.clr_last  = (k_reg == n_reg);
    assign sts.sv_done   = (i_sq > (2*CW)'(n_reg));
    assign sts.rd_comp   = rdata_reg;
    assign sts.mark_last = (j_step > (CW+1)'(n_reg));
    assign sts.scan_done = (p_reg > CW'(n_reg));
    assign sts.pow_done  = (pw_mul > (2*CW)'(n_reg));
    assign sts.mul_last  = (bc_reg == BC_END);
    assign sts.out_busy  = out_valid_reg;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== sv/lcm_of_first_n_mod_prime_unit.sv =====
// ----------------------------------------------------------------------------
// lcm_of_first_n_mod_prime_unit
// lcm(1..n) mod 1000000007 through a per-request sieve and prime powers.
// ----------------------------------------------------------------------------
//  channel  dir  tdata fields (lsb up)       handshake
//  s_       in   upper_limit[14:0], pad      s_tvalid / s_tready
//  m_       out  lcm_mod[29:0], pad          m_tvalid / m_tready
//
//  One request at a time; n is saturated to MAX_N. Each request runs a clear
//  pass over the bitmap, the sieve loop with its marks per sieve prime, the
//  prime scan, and per prime p<=n a power build and a bit-serial multiply,
//  then the output; the bitmap walks and the serial multiply set its length.
//  Reset clears the sequencer and output valid; the bitmap is cleared per
//  request. A finished result waits while the previous one is held on m_tready.
// ----------------------------------------------------------------------------
module lcm_of_first_n_mod_prime_unit #(
    parameter int unsigned MAX_N = 16384
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [14:0] upper_limit, [15] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata     // [29:0] lcm_mod, [31:30] zero
);
    import lcmfn_pkg::*;

    cmd_t              cmd;
    status_t           sts;
    logic [PROD_W-1:0] lcm_mod;

    lcmfn_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lcmfn_dp #(
        .MAX_N (MAX_N)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .limit_in  (s_tdata[14:0]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (lcm_mod)
    );

    assign m_tdata = {2'b00, lcm_mod};

    // a finished result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !m_tvalid)
        else $error("result loaded while previous transfer pending");

    a_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (lcm_mod < LCM_MOD))
        else $error("result not reduced modulo the prime");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted again while request in progress");

    a_mul_only_on_prime: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pow_start |-> !sts.rd_comp)
        else $error("prime power started on a composite");

endmodule

// ===== tb/lcm_of_first_n_mod_prime_unit_test.sv =====
// ----------------------------------------------------------------------------
// lcm_of_first_n_mod_prime_unit_test
// Streams upper limits into the unit and checks each lcm(1..n) mod 1000000007
// against a sieve-based software predictor. Covers the trivial limits, prime
// and prime-power edges, saturation above the cap, and a mixed random run
// with random idling on both channels.
// ----------------------------------------------------------------------------
module lcm_of_first_n_mod_prime_unit_test;

    localparam int unsigned     LIMIT_CAP = 16384;
    localparam longint unsigned PRIME_MOD = 64'd1000000007;

    typedef struct {
        logic [14:0] limit;
        logic [29:0] lcm;
    } pending_lcm_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;     // [14:0] upper_limit, [15] zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // [29:0] lcm_mod, [31:30] zero

    pending_lcm_t lcm_expected[$];
    int unsigned  mismatches = 0;
    int unsigned  results_checked = 0;
    int unsigned  limits_sent = 0;
    int unsigned  capped_sent = 0;
    bit           steady = 1'b0;

    lcm_of_first_n_mod_prime_unit #(.MAX_N(LIMIT_CAP)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 aclk = ~aclk;

    // lcm(1..n) mod prime: product of the largest power of each prime <= n
    function automatic logic [29:0] lcm_upto(input logic [14:0] limit);
        bit              composite [0:LIMIT_CAP];
        int unsigned     n;
        int unsigned     i;
        int unsigned     j;
        int unsigned     p;
        longint unsigned pw;
        longint unsigned acc;
        n = (limit > LIMIT_CAP) ? LIMIT_CAP : limit;
        for (i = 0; i <= n; i++) composite[i] = 1'b0;
        for (i = 2; i * i <= n; i++) begin
            if (!composite[i]) begin
                for (j = 2 * i; j <= n; j += i) composite[j] = 1'b1;
            end
        end
        acc = 1;
        for (p = 2; p <= n; p++) begin
            if (!composite[p]) begin
                pw = p;
                while (pw * p <= n) pw = pw * p;
                acc = (acc * pw) % PRIME_MOD;
            end
        end
        return acc[29:0];
    endfunction

    always @(posedge aclk) begin
        m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 24);
    end

    // input transfers queue a prediction, output transfers pop and compare
    always @(posedge aclk) begin
        pending_lcm_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                want.limit = s_tdata[14:0];
                want.lcm   = lcm_upto(s_tdata[14:0]);
                lcm_expected.insert(lcm_expected.size(), want);
            end
            if (m_tvalid && m_tready) begin
                if (lcm_expected.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, actual %0d",
                             $time, m_tdata[29:0]);
                end else begin
                    want = lcm_expected.pop_front();
                    results_checked++;
                    if (m_tdata[29:0] !== want.lcm) begin
                        mismatches++;
                        $display("%0t: lcm_mod for n=%0d: expected %0d, actual %0d",
                                 $time, want.limit, want.lcm, m_tdata[29:0]);
                    end
                end
            end
        end
    end

    task automatic send_limit(input logic [14:0] limit);
        int unsigned gap;
        if (!steady && $urandom_range(99) < 24) begin
            gap = $urandom_range(4, 1);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, limit};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        limits_sent++;
        if (limit >= LIMIT_CAP) capped_sent++;
    endtask

    // hold the input off until every outstanding result has come back
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (lcm_expected.size() != 0) @(posedge aclk);
    endtask

    task automatic run_small_limits();
        logic [14:0] edges[$];
        edges = '{0, 1, 2, 3, 4, 5, 7, 8, 9, 16, 17, 25, 27, 30, 31, 32, 100, 127, 128, 1000};
        foreach (edges[k]) send_limit(edges[k]);
        wait_for_results();
    endtask

    // above the cap the unit saturates; 32767 also sets every upper_limit bit
    task automatic run_saturated_limits();
        send_limit(15'd16384);
        send_limit(15'd16385);
        send_limit(15'h7fff);
        wait_for_results();
    endtask

    // mostly small limits, since cycles per request grow with n
    task automatic run_random_limits();
        int unsigned k;
        int unsigned r;
        for (k = 0; k < 100; k++) begin
            steady = (k >= 40 && k < 70);
            r = $urandom_range(99);
            if (r < 80)
                send_limit(15'($urandom_range(300)));
            else if (r < 96)
                send_limit(15'($urandom_range(2047, 301)));
            else
                send_limit(15'($urandom_range(8191, 2048)));
            if (k == 70) wait_for_results();
        end
        steady = 1'b0;
        wait_for_results();
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_small_limits();
        run_saturated_limits();
        run_random_limits();
        repeat (200) @(posedge aclk);
        $display("%0d limits sent (%0d at or above the cap), %0d results compared",
                 limits_sent, capped_sent, results_checked);
        $display("%0d mismatches", mismatches);
        if (mismatches == 0 && lcm_expected.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("%0t: timeout with %0d results outstanding", $time, lcm_expected.size());
        $display("status: fail");
        $finish;
    end

endmodule
